// ===== rtl/pair_seen_table_with_aging_macros.svh =====
// Assertion macros shared by the aging pair table RTL.
`ifndef PAIR_SEEN_TABLE_WITH_AGING_MACROS_SVH
`define PAIR_SEEN_TABLE_WITH_AGING_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PSTWA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pstwa check failed");

// Next-cycle implication, disabled while reset is high.
`define PSTWA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pstwa check failed");

`endif

// ===== rtl/pstwa_pkg.sv =====
// Package with constants and types of the aging pair table.
package pstwa_pkg;

  // Default sizes of the table.
  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_KEY_BITS      = 16;

  // Age counters and occupancy report.
  localparam int AGE_BITS   = 4;
  localparam int AGE_LEVELS = 1 << AGE_BITS;
  localparam int OCC_BITS   = 7;
  localparam int OCC_MAX    = 127;

  localparam logic [AGE_BITS-1:0] LIFETIME_RESET = 4'd10;

  // Operation codes.
  localparam logic OP_SIGNAL = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Command issued to the table for one transaction.
  typedef struct packed {
    logic                pair_op;
    logic                tick_op;
    logic [AGE_BITS-1:0] lifetime;
  } cmd_t;

  // Lookup outcome returned by the table.
  typedef struct packed {
    logic                hit;
    logic                stored;
    logic                dropped;
    logic [AGE_BITS-1:0] hit_age;
  } lookup_t;

endpackage

// ===== rtl/pstwa_table.sv =====
// Associative pair table: parallel match, first-free insert and parallel aging.
module pstwa_table #(
  parameter int TABLE_ENTRIES = pstwa_pkg::DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = pstwa_pkg::DEF_KEY_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pstwa_pkg::cmd_t       cmd,
  input  logic [KEY_BITS-1:0]   first_key,
  input  logic [KEY_BITS-1:0]   second_key,
  output pstwa_pkg::lookup_t    lookup
);

  logic [TABLE_ENTRIES-1:0]                 entry_valid;
  logic [KEY_BITS-1:0]                      entry_first  [TABLE_ENTRIES];
  logic [KEY_BITS-1:0]                      entry_second [TABLE_ENTRIES];
  logic [pstwa_pkg::AGE_BITS-1:0]           entry_age    [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0]                 match;
  logic [TABLE_ENTRIES-1:0]                 free;
  logic [TABLE_ENTRIES-1:0]                 free_first;
  logic [pstwa_pkg::AGE_BITS-1:0]           hit_age;
  logic                                     any_hit;
  logic                                     full;
  logic                                     insert;

  // Compare the key pair against every valid entry at once.
  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      match[k] = entry_valid[k] && (entry_first[k] == first_key) &&
                 (entry_second[k] == second_key);
    end
  end

  // Age of the matching entry; at most one entry can match.
  always_comb begin
    hit_age = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      hit_age = hit_age | (match[k] ? entry_age[k] : '0);
    end
  end

  // Lowest-numbered free entry as a one-hot vector.
  assign free       = ~entry_valid;
  assign free_first = free & (~free + TABLE_ENTRIES'(1));
  assign full       = ~|free;
  assign any_hit    = |match;
  assign insert     = cmd.pair_op && !any_hit && !full;

  assign lookup.hit     = cmd.pair_op && any_hit;
  assign lookup.stored  = insert;
  assign lookup.dropped = cmd.pair_op && !any_hit && full;
  assign lookup.hit_age = hit_age;

  // Valid bits: cleared at reset, set on insert, cleared when aged out.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (cmd.tick_op) begin
          if (entry_valid[k] && (entry_age[k] == '0)) begin
            entry_valid[k] <= 1'b0;
          end
        end else if (insert && free_first[k]) begin
          entry_valid[k] <= 1'b1;
        end
      end
    end
  end

  // Keys and age counters.
  always_ff @(posedge clk) begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (cmd.tick_op) begin
        if (entry_valid[k] && (entry_age[k] != '0)) begin
          entry_age[k] <= entry_age[k] - pstwa_pkg::AGE_BITS'(1);
        end
      end else if (cmd.pair_op && match[k]) begin
        entry_age[k] <= cmd.lifetime;
      end else if (insert && free_first[k]) begin
        entry_first[k]  <= first_key;
        entry_second[k] <= second_key;
        entry_age[k]    <= cmd.lifetime;
      end
    end
  end

endmodule

// ===== rtl/pstwa_count.sv =====
// Occupancy tracking through a histogram of entries per age value.
module pstwa_count #(
  parameter int TABLE_ENTRIES = pstwa_pkg::DEF_TABLE_ENTRIES,
  localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pstwa_pkg::cmd_t                 cmd,
  input  pstwa_pkg::lookup_t              lookup,
  output logic [CNT_W-1:0]                occ,
  output logic [pstwa_pkg::OCC_BITS-1:0]  occ_after
);

  localparam int SAT_W = (CNT_W > pstwa_pkg::OCC_BITS) ? CNT_W : pstwa_pkg::OCC_BITS;

  logic [CNT_W-1:0] hist      [pstwa_pkg::AGE_LEVELS];
  logic [CNT_W-1:0] hist_next [pstwa_pkg::AGE_LEVELS];
  logic [CNT_W-1:0] occ_next;
  logic [SAT_W-1:0] occ_wide;

  // Next histogram: shift down on a tick, move or add one entry on a signal.
  always_comb begin
    for (int i = 0; i < pstwa_pkg::AGE_LEVELS; i++) begin
      if (cmd.tick_op) begin
        hist_next[i] = (i == pstwa_pkg::AGE_LEVELS - 1) ? '0 : hist[(i + 1) % pstwa_pkg::AGE_LEVELS];
      end else begin
        hist_next[i] = hist[i]
          + CNT_W'((lookup.hit || lookup.stored) && (cmd.lifetime == pstwa_pkg::AGE_BITS'(i)))
          - CNT_W'(lookup.hit && (lookup.hit_age == pstwa_pkg::AGE_BITS'(i)));
      end
    end
  end

  // Entries at age zero leave on a tick; an insert adds one.
  always_comb begin
    if (cmd.tick_op) begin
      occ_next = occ - hist[0];
    end else begin
      occ_next = occ + CNT_W'(lookup.stored);
    end
  end

  // Reported occupancy saturates at the field maximum.
  assign occ_wide  = SAT_W'(occ_next);
  assign occ_after = (occ_wide > SAT_W'(pstwa_pkg::OCC_MAX)) ?
                     pstwa_pkg::OCC_BITS'(pstwa_pkg::OCC_MAX) :
                     pstwa_pkg::OCC_BITS'(occ_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      for (int i = 0; i < pstwa_pkg::AGE_LEVELS; i++) begin
        hist[i] <= '0;
      end
    end else begin
      occ <= occ_next;
      for (int i = 0; i < pstwa_pkg::AGE_LEVELS; i++) begin
        hist[i] <= hist_next[i];
      end
    end
  end

endmodule

// ===== rtl/pair_seen_table_with_aging.sv =====
// Top level of the aging pair table.
//
// Input channel (in_valid/in_ready) carries one transaction per item: opcode 0
// looks up the ordered pair (first_key, second_key) and inserts it when absent,
// opcode 1 ages every stored entry by one tick. Output channel
// (out_valid/out_ready) returns one transaction per item with is_new,
// insert_dropped and the occupancy after the item.
// The lifetime loaded on every signal is written through cfg_wr_en/cfg_wr_data.
// An item is captured in the input register; when it fires, the table lookup,
// update and occupancy count run together and land in the result register.
// One item completes every cycle while the receiver does not stall; the rate is
// set by the parallel match and aging over all table entries.
// Reset empties the table, clears both pipeline registers and loads lifetime 10.
// When the receiver stalls, the result register holds its transaction, the
// input register takes one more item, and in_ready then drops until the
// result is taken.
`include "pair_seen_table_with_aging_macros.svh"

module pair_seen_table_with_aging #(
  parameter int TABLE_ENTRIES = pstwa_pkg::DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = pstwa_pkg::DEF_KEY_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [KEY_BITS-1:0]              first_key,
  input  logic [KEY_BITS-1:0]              second_key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             is_new,
  output logic                             insert_dropped,
  output logic [pstwa_pkg::OCC_BITS-1:0]   occupancy,
  input  logic                             cfg_wr_en,
  input  logic [pstwa_pkg::AGE_BITS-1:0]   cfg_wr_data
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic                            s1_valid;
  logic                            s1_opcode;
  logic [KEY_BITS-1:0]             s1_first;
  logic [KEY_BITS-1:0]             s1_second;
  logic [pstwa_pkg::AGE_BITS-1:0]  lifetime_ticks;
  logic                            fire;
  pstwa_pkg::cmd_t                 cmd;
  pstwa_pkg::lookup_t              lookup;
  logic [CNT_W-1:0]                occ;
  logic [pstwa_pkg::OCC_BITS-1:0]  occ_after;

  // The held item is processed whenever the result register can take it.
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  // Lifetime register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime_ticks <= pstwa_pkg::LIFETIME_RESET;
    end else if (cfg_wr_en) begin
      lifetime_ticks <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_first  <= first_key;
      s1_second <= second_key;
    end
  end

  // Command for the table and the counter.
  assign cmd.pair_op  = fire && (s1_opcode == pstwa_pkg::OP_SIGNAL);
  assign cmd.tick_op  = fire && (s1_opcode == pstwa_pkg::OP_TICK);
  assign cmd.lifetime = lifetime_ticks;

  pstwa_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .first_key  (s1_first),
    .second_key (s1_second),
    .lookup     (lookup)
  );

  pstwa_count #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_count (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .lookup    (lookup),
    .occ       (occ),
    .occ_after (occ_after)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      is_new         <= cmd.pair_op && !lookup.hit;
      insert_dropped <= lookup.dropped;
      occupancy      <= occ_after;
    end
  end

  // A dropped insert only happens with every entry occupied.
  `PSTWA_ASSERT_NOW(a_drop_when_full, clk, rst, lookup.dropped, occ == CNT_W'(TABLE_ENTRIES))
  // A stored insert raises the occupancy by exactly one.
  `PSTWA_ASSERT_NEXT(a_insert_counts, clk, rst, lookup.stored, occ == $past(occ) + CNT_W'(1))
  // A dropped insert is always reported as a new pair.
  `PSTWA_ASSERT_NOW(a_drop_is_new, clk, rst, out_valid && insert_dropped, is_new)

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the aging pair table, with its own shadow model of the table.
`timescale 1ns / 1ps

module tb;

  localparam int KEY_W       = pstwa_pkg::DEF_KEY_BITS;
  localparam int SLOTS       = pstwa_pkg::DEF_TABLE_ENTRIES;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 4000;
  localparam int REPORT_MAX  = 10;

  // One input transaction and one result transaction.
  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] first_k;
    logic [KEY_W-1:0] second_k;
  } pair_item_t;

  typedef struct packed {
    logic                           is_new;
    logic                           dropped;
    logic [pstwa_pkg::OCC_BITS-1:0] occ;
  } outcome_t;

  // Block ports; the inputs are driven to known values from time zero.
  logic                           clk            = 1'b0;
  logic                           rst            = 1'b1;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic                           opcode         = pstwa_pkg::OP_SIGNAL;
  logic [KEY_W-1:0]               first_key      = '0;
  logic [KEY_W-1:0]               second_key     = '0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic                           is_new;
  logic                           insert_dropped;
  logic [pstwa_pkg::OCC_BITS-1:0] occupancy;
  logic                           cfg_wr_en      = 1'b0;
  logic [pstwa_pkg::AGE_BITS-1:0] cfg_wr_data    = '0;

  // Stimulus and checking state.
  pair_item_t          pair_items[$];
  outcome_t            lookup_outcomes[$];
  logic [KEY_W-1:0]    key_pool[16];
  int                  send_idle_pct  = 0;
  int                  recv_idle_pct  = 0;
  int                  stall_req      = 0;
  int                  stall_seen     = 0;
  int                  stall_left     = 0;
  int                  stuck_cycles   = 0;
  int                  mismatches     = 0;
  logic                in_taken       = 1'b0;
  logic                out_taken      = 1'b0;

  // Shadow copy of the pair table and its lifetime register.
  logic                           slot_valid[SLOTS];
  logic [KEY_W-1:0]               slot_first[SLOTS];
  logic [KEY_W-1:0]               slot_second[SLOTS];
  logic [pstwa_pkg::AGE_BITS-1:0] slot_age[SLOTS];
  logic [pstwa_pkg::AGE_BITS-1:0] lifetime_shadow;

  pair_seen_table_with_aging u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .first_key      (first_key),
    .second_key     (second_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_new         (is_new),
    .insert_dropped (insert_dropped),
    .occupancy      (occupancy),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one transaction to the shadow table and returns the result it should produce.
  function automatic outcome_t table_update(logic op, logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    outcome_t r;
    int       hit;
    int       free_slot;
    int       n;
    r         = '0;
    hit       = -1;
    free_slot = -1;
    n         = 0;
    if (op == pstwa_pkg::OP_TICK) begin
      // Entries already at zero age leave; all others count down.
      for (int k = 0; k < SLOTS; k++) begin
        if (slot_valid[k]) begin
          if (slot_age[k] == '0) slot_valid[k] = 1'b0;
          else slot_age[k] = slot_age[k] - 1'b1;
        end
      end
    end else begin
      // Match against valid entries, and find the lowest free slot.
      for (int k = 0; k < SLOTS; k++) begin
        if (slot_valid[k]) begin
          if (hit < 0 && slot_first[k] == a && slot_second[k] == b) hit = k;
        end else if (free_slot < 0) begin
          free_slot = k;
        end
      end
      if (hit >= 0) begin
        slot_age[hit] = lifetime_shadow;
      end else begin
        r.is_new = 1'b1;
        if (free_slot >= 0) begin
          slot_valid[free_slot]  = 1'b1;
          slot_first[free_slot]  = a;
          slot_second[free_slot] = b;
          slot_age[free_slot]    = lifetime_shadow;
        end else begin
          r.dropped = 1'b1;
        end
      end
    end
    for (int k = 0; k < SLOTS; k++) n += int'(slot_valid[k]);
    r.occ = pstwa_pkg::OCC_BITS'((n > pstwa_pkg::OCC_MAX) ? pstwa_pkg::OCC_MAX : n);
    return r;
  endfunction

  // Mostly pairs from a small key pool so that hits and a full table occur.
  function automatic pair_item_t random_pair(int tick_pct, int pool);
    pair_item_t it;
    it.op       = pstwa_pkg::OP_SIGNAL;
    it.first_k  = KEY_W'($urandom_range(16'hFFFF));
    it.second_k = KEY_W'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < tick_pct) begin
      it.op = pstwa_pkg::OP_TICK;
    end else if ($urandom_range(9) != 0) begin
      it.first_k  = key_pool[$urandom_range(pool - 1)];
      it.second_k = key_pool[$urandom_range(pool - 1)];
    end
    return it;
  endfunction

  task automatic push_pair(logic op, logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    pair_item_t it;
    it = '{op, a, b};
    pair_items.insert(pair_items.size(), it);
  endtask

  task automatic queue_random(int count, int tick_pct, int pool);
    for (int i = 0; i < count; i++)
      pair_items.insert(pair_items.size(), random_pair(tick_pct, pool));
  endtask

  // Returns once every queued transaction has been sent and every result has arrived.
  task automatic wait_drained();
    @(posedge clk);
    while (pair_items.size() != 0 || in_valid || lookup_outcomes.size() != 0) @(posedge clk);
  endtask

  // Writes the lifetime register while the block is idle.
  task automatic write_lifetime(logic [pstwa_pkg::AGE_BITS-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // Input driver: presents the next pending transaction once the current one is taken.
  always @(negedge clk) begin
    pair_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pair_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt        = pair_items.pop_front();
        in_valid   <= 1'b1;
        opcode     <= nxt.op;
        first_key  <= nxt.first_k;
        second_key <= nxt.second_k;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen = stall_req;
      stall_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each result transaction, then predicts for each accepted input.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        got       = '{is_new, insert_dropped, occupancy};
        if (lookup_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result is_new=%0b insert_dropped=%0b occupancy=%0d",
                     $realtime, got.is_new, got.dropped, got.occ);
        end else begin
          want = lookup_outcomes.pop_front();
          if (got.is_new !== want.is_new || got.dropped !== want.dropped ||
              got.occ !== want.occ) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: expected is_new=%0b insert_dropped=%0b occupancy=%0d, got %0b %0b %0d",
                       $realtime, want.is_new, want.dropped, want.occ,
                       got.is_new, got.dropped, got.occ);
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        lookup_outcomes.insert(lookup_outcomes.size(),
                               table_update(opcode, first_key, second_key));
      end
      if (cfg_wr_en) lifetime_shadow = cfg_wr_data;
    end
  end

  // Watchdog: ends the run when work is outstanding but nothing moves.
  always @(negedge clk) begin
    if (in_taken || out_taken ||
        (pair_items.size() == 0 && !in_valid && lookup_outcomes.size() == 0))
      stuck_cycles = 0;
    else
      stuck_cycles = stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Phase sequencing.
  initial begin
    pair_item_t fill0;
    for (int k = 0; k < SLOTS; k++) begin
      slot_valid[k]  = 1'b0;
      slot_first[k]  = '0;
      slot_second[k] = '0;
      slot_age[k]    = '0;
    end
    lifetime_shadow = pstwa_pkg::LIFETIME_RESET;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < 16; k++) key_pool[k] = KEY_W'($urandom_range(16'hFFFF));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender rarely idles, receiver mostly stalls.
    send_idle_pct = 10;
    recv_idle_pct = 79;
    @(posedge clk);

    // Directed: tick on an empty table, key extremes, hit, ordered pairs, at reset lifetime.
    push_pair(pstwa_pkg::OP_TICK,   '0, '0);
    push_pair(pstwa_pkg::OP_SIGNAL, '0, '0);
    push_pair(pstwa_pkg::OP_SIGNAL, '0, '0);
    push_pair(pstwa_pkg::OP_SIGNAL, '1, '1);
    push_pair(pstwa_pkg::OP_SIGNAL, 16'd1, 16'd2);
    push_pair(pstwa_pkg::OP_SIGNAL, 16'd2, 16'd1);
    push_pair(pstwa_pkg::OP_SIGNAL, '1, '0);
    push_pair(pstwa_pkg::OP_SIGNAL, '0, '1);
    push_pair(pstwa_pkg::OP_TICK,   '1, '1);
    push_pair(pstwa_pkg::OP_SIGNAL, '0, '0);

    // Zero lifetime: the pair lives until the next tick.
    write_lifetime(4'd0);
    push_pair(pstwa_pkg::OP_SIGNAL, 16'd5, 16'd6);
    push_pair(pstwa_pkg::OP_SIGNAL, 16'd5, 16'd6);
    push_pair(pstwa_pkg::OP_TICK,   16'd0, 16'd0);
    push_pair(pstwa_pkg::OP_SIGNAL, 16'd5, 16'd6);
    push_pair(pstwa_pkg::OP_TICK,   16'd0, 16'd0);

    // Empty the table, then overfill it and hit a stored pair while full.
    write_lifetime(4'd15);
    for (int i = 0; i < 16; i++) push_pair(pstwa_pkg::OP_TICK, '0, '0);
    fill0 = random_pair(0, 16);
    fill0.first_k = KEY_W'($urandom_range(16'hFFFF));
    push_pair(pstwa_pkg::OP_SIGNAL, fill0.first_k, fill0.second_k);
    queue_random(70, 0, 16);
    for (int i = 0; i < 70; i++) pair_items[pair_items.size() - 1 - i].first_k =
        KEY_W'($urandom_range(16'hFFFF));
    push_pair(pstwa_pkg::OP_SIGNAL, fill0.first_k, fill0.second_k);
    push_pair(pstwa_pkg::OP_TICK,   '0, '0);

    // Long receiver hold-off while the sender keeps offering transactions.
    write_lifetime(4'd15);
    stall_req = stall_req + 1;
    queue_random(320, 3, 16);

    // Sender mostly idles, receiver rarely stalls.
    write_lifetime(4'd1);
    send_idle_pct = 79;
    recv_idle_pct = 10;
    queue_random(320, 20, 8);
    write_lifetime(pstwa_pkg::AGE_BITS'($urandom_range(15)));
    queue_random(320, 8, 12);

    // No idling on either side.
    write_lifetime(4'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(300, 30, 4);
    write_lifetime(4'd15);
    queue_random(320, 2, 16);
    write_lifetime(pstwa_pkg::AGE_BITS'($urandom_range(15)));
    queue_random(320, 10, 16);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pstwa_pkg.sv
rtl/pstwa_table.sv
rtl/pstwa_count.sv
rtl/pair_seen_table_with_aging.sv
bench/tb.sv
